// ===== rtl/save_slot_rotation_selector_macros.svh =====
// Assertion macros used by the save slot selector RTL.
`ifndef SAVE_SLOT_ROTATION_SELECTOR_MACROS_SVH
`define SAVE_SLOT_ROTATION_SELECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sssr_pkg.sv =====
// Types and constants for the save slot rotation selector.
package sssr_pkg;

  localparam int unsigned SLOT_W = 4;
  localparam int unsigned VER_W  = 32;

  localparam logic [31:0] SIG_RESET  = 32'h4547_474D;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] WRAP_LIMIT = 32'h0000_FFFF;

  typedef struct packed {
    logic [31:0] header_signature;
    logic [31:0] header_version;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] write_slot;
    logic              write_slot_found;
    logic [SLOT_W-1:0] newest_slot;
  } out_item_t;

  // One scan step toward the scan unit.
  typedef struct packed {
    logic step;
    logic hit;
  } scan_req_t;

endpackage

// ===== rtl/save_slot_rotation_selector.sv =====
// Top level of the save slot rotation selector.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  in      | in_valid in_ready in_data      | one sector header, in sector order
//  out     | out_valid out_ready out_data   | write target and newest sector
//  cfg     | cfg_valid cfg_ready cfg_data   | signature word
//
// One header per cycle unless a last header waits on a busy result: a header is
// captured in the input register and folded into the scan registers as it advances.
// A round's result is taken as its last header advances and held in the output
// register. Reset is synchronous and leaves the signature at its default and the
// scan empty. A stalled result holds back only the last header of the next round.
module save_slot_rotation_selector #(
  parameter int SECTOR_COUNT = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sssr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sssr_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);

  `include "save_slot_rotation_selector_macros.svh"

  logic [31:0]                signature_r;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_hit_r;
  logic [sssr_pkg::VER_W-1:0] s1_ver_r;
  logic                       s1_go;
  logic                       s1_last;
  logic                       out_valid_r, out_valid_nxt;
  sssr_pkg::out_item_t        out_data_r;
  sssr_pkg::out_item_t        scan_res;
  sssr_pkg::scan_req_t        scan_req;

  assign cfg_ready = 1'b1;

  // Advance the captured header unless it closes a round and the result slot is busy.
  assign s1_go    = s1_valid_r && (!s1_last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign scan_req.step = s1_go;
  assign scan_req.hit  = s1_hit_r;

  sssr_scan #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (scan_req),
    .version (s1_ver_r),
    .last    (s1_last),
    .res     (scan_res)
  );

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_go);
  assign out_valid_nxt = (s1_go && s1_last) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signature_r <= sssr_pkg::SIG_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        signature_r <= cfg_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_hit_r <= (in_data.header_signature == signature_r);
      s1_ver_r <= in_data.header_version;
    end
    if (s1_go && s1_last) begin
      out_data_r <= scan_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSSR_ASSERT_NEXT(a_last_gives_result, s1_go && s1_last, out_valid_r,
    "round closed without a result")
  `SSSR_ASSERT_NOW(a_no_target_zero, out_valid_r && !out_data_r.write_slot_found,
    out_data_r.write_slot == '0, "missing write target must report sector zero")
  `SSSR_ASSERT_NOW(a_last_blocks, s1_valid_r && s1_last && out_valid_r && !out_ready,
    !in_ready && !s1_go, "last header advanced into a busy result register")

endmodule

// ===== rtl/sssr_scan.sv =====
// Running scan state over the sector headers and the end-of-round decision.
module sssr_scan #(
  parameter int SECTOR_COUNT = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sssr_pkg::scan_req_t           req,
  input  logic [sssr_pkg::VER_W-1:0]    version,
  output logic                          last,
  output sssr_pkg::out_item_t           res
);

  localparam logic [sssr_pkg::SLOT_W-1:0] LAST_SLOT = sssr_pkg::SLOT_W'(SECTOR_COUNT - 1);

  logic [sssr_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        empty_seen_r, empty_seen_nxt;
  logic [sssr_pkg::SLOT_W-1:0] empty_slot_r, empty_slot_nxt;
  logic [31:0]                 omax_r, omax_nxt;
  logic [31:0]                 omin_r, omin_nxt;
  logic [sssr_pkg::SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [31:0]                 vmax_r, vmax_nxt;
  logic [31:0]                 vmin_r, vmin_nxt;
  logic [sssr_pkg::SLOT_W-1:0] newest_r, newest_nxt;
  logic [31:0]                 wmax_r, wmax_nxt;
  logic [sssr_pkg::SLOT_W-1:0] wslot_r, wslot_nxt;
  logic                        wtaken_r, wtaken_nxt;

  // Values after folding in the current header.
  logic                        empty_seen_u;
  logic [sssr_pkg::SLOT_W-1:0] empty_slot_u;
  logic [31:0]                 omax_u, omin_u, vmax_u, vmin_u, wmax_u;
  logic [sssr_pkg::SLOT_W-1:0] oldest_u, newest_u, wslot_u;
  logic                        wtaken_u;

  assign last = (slot_r == LAST_SLOT);

  always_comb begin
    empty_seen_u = empty_seen_r | ~req.hit;
    empty_slot_u = empty_seen_r ? empty_slot_r : slot_r;

    omax_u = (version > omax_r) ? version : omax_r;

    omin_u   = omin_r;
    oldest_u = oldest_r;
    if (version < omin_r) begin
      omin_u   = version;
      oldest_u = slot_r;
    end

    vmax_u   = vmax_r;
    newest_u = newest_r;
    vmin_u   = vmin_r;
    if (req.hit) begin
      if (version > vmax_r) begin
        vmax_u   = version;
        newest_u = slot_r;
      end
      if (version < vmin_r) begin
        vmin_u = version;
      end
    end

    wmax_u   = wmax_r;
    wslot_u  = wslot_r;
    wtaken_u = wtaken_r;
    if ((wmax_r <= sssr_pkg::WRAP_LIMIT) && (version > wmax_r)) begin
      wmax_u   = version;
      wslot_u  = slot_r;
      wtaken_u = 1'b1;
    end
  end

  always_comb begin
    if (empty_seen_u) begin
      res.write_slot       = empty_slot_u;
      res.write_slot_found = 1'b1;
    end else if (omax_u != sssr_pkg::ALL_ONES) begin
      res.write_slot       = oldest_u;
      res.write_slot_found = 1'b1;
    end else begin
      res.write_slot       = '0;
      res.write_slot_found = 1'b0;
    end
    res.newest_slot = ((vmin_u == '0) && wtaken_u) ? wslot_u : newest_u;
  end

  always_comb begin
    slot_nxt       = slot_r;
    empty_seen_nxt = empty_seen_r;
    empty_slot_nxt = empty_slot_r;
    omax_nxt       = omax_r;
    omin_nxt       = omin_r;
    oldest_nxt     = oldest_r;
    vmax_nxt       = vmax_r;
    vmin_nxt       = vmin_r;
    newest_nxt     = newest_r;
    wmax_nxt       = wmax_r;
    wslot_nxt      = wslot_r;
    wtaken_nxt     = wtaken_r;
    if (req.step) begin
      if (last) begin
        // round done: start over
        slot_nxt       = '0;
        empty_seen_nxt = 1'b0;
        empty_slot_nxt = '0;
        omax_nxt       = '0;
        omin_nxt       = sssr_pkg::ALL_ONES;
        oldest_nxt     = '0;
        vmax_nxt       = '0;
        vmin_nxt       = sssr_pkg::ALL_ONES;
        newest_nxt     = '0;
        wmax_nxt       = '0;
        wslot_nxt      = '0;
        wtaken_nxt     = 1'b0;
      end else begin
        slot_nxt       = slot_r + 1'b1;
        empty_seen_nxt = empty_seen_u;
        empty_slot_nxt = empty_slot_u;
        omax_nxt       = omax_u;
        omin_nxt       = omin_u;
        oldest_nxt     = oldest_u;
        vmax_nxt       = vmax_u;
        vmin_nxt       = vmin_u;
        newest_nxt     = newest_u;
        wmax_nxt       = wmax_u;
        wslot_nxt      = wslot_u;
        wtaken_nxt     = wtaken_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= '0;
      empty_seen_r <= 1'b0;
      empty_slot_r <= '0;
      omax_r       <= '0;
      omin_r       <= sssr_pkg::ALL_ONES;
      oldest_r     <= '0;
      vmax_r       <= '0;
      vmin_r       <= sssr_pkg::ALL_ONES;
      newest_r     <= '0;
      wmax_r       <= '0;
      wslot_r      <= '0;
      wtaken_r     <= 1'b0;
    end else begin
      slot_r       <= slot_nxt;
      empty_seen_r <= empty_seen_nxt;
      empty_slot_r <= empty_slot_nxt;
      omax_r       <= omax_nxt;
      omin_r       <= omin_nxt;
      oldest_r     <= oldest_nxt;
      vmax_r       <= vmax_nxt;
      vmin_r       <= vmin_nxt;
      newest_r     <= newest_nxt;
      wmax_r       <= wmax_nxt;
      wslot_r      <= wslot_nxt;
      wtaken_r     <= wtaken_nxt;
    end
  end

endmodule
